FILE: sv/qrs_pkg.sv
// Shared types and constants for the quadratic root solver
`timescale 1ns / 1ps
`default_nettype none
package qrs_pkg;

    // Coefficient width (signed Q8.8)
    localparam int CW = 16;
    // Root field width (signed Q16.16)
    localparam int OW = 32;
    // Discriminant width, signed; |B*B - 4AC| stays below 2^33
    localparam int DW = 34;
    // Square root radicand width and result width
    localparam int XW = 64;
    localparam int RW = 32;
    localparam int SQRT_STEPS = RW;
    // Square root partial remainder width
    localparam int MW = RW + 4;
    // Numerator width, signed
    localparam int NW = 34;
    // Dividend (2|N| + |A|) and quotient width
    localparam int QW = 35;
    localparam int DIV_STEPS = QW;
    // Divisor width (2|A| reaches 2^16)
    localparam int VW = CW + 1;
    // Number of divider lanes
    localparam int LANES = 2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_AZERO = 2'd1,
        ST_SAT   = 2'd2
    } status_t;

    // Side information carried next to the square root
    typedef struct packed {
        logic signed [CW-1:0] quad;
        logic signed [OW-1:0] neg_lin;
        logic                 cplx;
        logic                 zero;
    } sqrt_tag_t;

    // Side information carried next to the divider
    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic cplx;
        logic zero;
    } div_tag_t;

endpackage
`default_nettype wire

FILE: sv/qrs_front.sv
// Discriminant front end: products, then discriminant and radicand
`timescale 1ns / 1ps
`default_nettype none
module qrs_front
    import qrs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 vin,
    input  wire logic signed [CW-1:0] quad,
    input  wire logic signed [CW-1:0] lin,
    input  wire logic signed [CW-1:0] cnst,
    output logic                      vout,
    output logic [XW-1:0]             rad,
    output sqrt_tag_t                 tag
);

    logic                   v1_reg;
    logic signed [2*CW-1:0] bb_reg;
    logic signed [2*CW-1:0] ac_reg;
    logic signed [CW-1:0]   a1_reg;
    logic signed [CW-1:0]   b1_reg;

    logic signed [DW-1:0]   d_next;
    logic        [DW-1:0]   ud_next;
    logic                   v2_reg;
    logic [XW-1:0]          rad_reg;
    sqrt_tag_t              tag_reg;
    sqrt_tag_t              tag_next;

    // Stage 1 and stage 2 valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= vin;
            v2_reg <= v1_reg;
        end
    end

    // Stage 1: the two products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bb_reg <= (2*CW)'(lin) * (2*CW)'(lin);
            ac_reg <= (2*CW)'(quad) * (2*CW)'(cnst);
            a1_reg <= quad;
            b1_reg <= lin;
        end
    end

    // Stage 2: discriminant, magnitude, radicand scaled by 2^30
    always_comb
    begin
        d_next  = DW'(bb_reg) - (DW'(ac_reg) <<< 2);
        ud_next = d_next[DW-1] ? DW'(-d_next) : DW'(d_next);
        tag_next.quad    = a1_reg;
        tag_next.neg_lin = -(OW'(b1_reg) <<< 15);
        tag_next.cplx    = d_next[DW-1];
        tag_next.zero    = (a1_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg <= XW'(ud_next) << 30;
            tag_reg <= tag_next;
        end
    end

    assign vout = v2_reg;
    assign rad  = rad_reg;
    assign tag  = tag_reg;

endmodule
`default_nettype wire

FILE: sv/qrs_isqrt.sv
// Pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
`default_nettype none
module qrs_isqrt
    import qrs_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          vin,
    input  wire logic [XW-1:0] rad,
    input  sqrt_tag_t          tag_in,
    output logic               vout,
    output logic [RW-1:0]      root,
    output sqrt_tag_t          tag_out
);

    logic            v_reg    [0:SQRT_STEPS-1];
    logic [XW-1:0]   x_reg    [0:SQRT_STEPS-1];
    logic [MW-1:0]   rem_reg  [0:SQRT_STEPS-1];
    logic [RW-1:0]   root_reg [0:SQRT_STEPS-1];
    sqrt_tag_t       tag_reg  [0:SQRT_STEPS-1];

    for (genvar s = 0; s < SQRT_STEPS; s++)
    begin : g_step
        logic          v_in;
        logic [XW-1:0] x_in;
        logic [MW-1:0] rem_in;
        logic [RW-1:0] root_in;
        sqrt_tag_t     tag_s;
        logic [MW-1:0] rem_sh;
        logic [MW-1:0] trial;
        logic          take;

        if (s == 0)
        begin : g_first
            assign v_in    = vin;
            assign x_in    = rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign tag_s   = tag_in;
        end
        else
        begin : g_next
            assign v_in    = v_reg[s-1];
            assign x_in    = x_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign tag_s   = tag_reg[s-1];
        end

        // Bring down two radicand bits and try root*4+1
        assign rem_sh = {rem_in[MW-3:0], x_in[XW-1:XW-2]};
        assign trial  = MW'({root_in, 2'b01});
        assign take   = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else if (en)
                v_reg[s] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[s]    <= x_in << 2;
                rem_reg[s]  <= take ? (rem_sh - trial) : rem_sh;
                root_reg[s] <= {root_in[RW-2:0], take};
                tag_reg[s]  <= tag_s;
            end
        end
    end

    assign vout    = v_reg[SQRT_STEPS-1];
    assign root    = root_reg[SQRT_STEPS-1];
    assign tag_out = tag_reg[SQRT_STEPS-1];

endmodule
`default_nettype wire

FILE: sv/qrs_div.sv
// Two-lane pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module qrs_div
    import qrs_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          vin,
    input  wire logic [QW-1:0] num_x,
    input  wire logic [QW-1:0] num_y,
    input  wire logic [VW-1:0] den,
    input  div_tag_t           tag_in,
    output logic               vout,
    output logic [QW-1:0]      quo_x,
    output logic [QW-1:0]      quo_y,
    output div_tag_t           tag_out
);

    logic          v_reg   [0:DIV_STEPS-1];
    logic [VW-1:0] den_reg [0:DIV_STEPS-1];
    div_tag_t      tag_reg [0:DIV_STEPS-1];
    logic [QW-1:0] num_reg [0:DIV_STEPS-1][0:LANES-1];
    logic [QW-1:0] quo_reg [0:DIV_STEPS-1][0:LANES-1];
    logic [VW-1:0] rem_reg [0:DIV_STEPS-1][0:LANES-1];

    for (genvar s = 0; s < DIV_STEPS; s++)
    begin : g_step
        logic          v_in;
        logic [VW-1:0] den_in;
        div_tag_t      tag_s;

        if (s == 0)
        begin : g_first
            assign v_in   = vin;
            assign den_in = den;
            assign tag_s  = tag_in;
        end
        else
        begin : g_next
            assign v_in   = v_reg[s-1];
            assign den_in = den_reg[s-1];
            assign tag_s  = tag_reg[s-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else if (en)
                v_reg[s] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[s] <= den_in;
                tag_reg[s] <= tag_s;
            end
        end

        for (genvar l = 0; l < LANES; l++)
        begin : g_lane
            logic [QW-1:0] num_in;
            logic [QW-1:0] quo_in;
            logic [VW-1:0] rem_in;
            logic [VW:0]   part;
            logic          take;

            if (s == 0)
            begin : g_first
                assign num_in = (l == 0) ? num_x : num_y;
                assign quo_in = '0;
                assign rem_in = '0;
            end
            else
            begin : g_next
                assign num_in = num_reg[s-1][l];
                assign quo_in = quo_reg[s-1][l];
                assign rem_in = rem_reg[s-1][l];
            end

            // Shift in the next dividend bit and trial-subtract
            assign part = {rem_in, num_in[QW-1]};
            assign take = (part >= {1'b0, den_in});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    num_reg[s][l] <= num_in << 1;
                    quo_reg[s][l] <= {quo_in[QW-2:0], take};
                    rem_reg[s][l] <= take ? VW'(part - {1'b0, den_in}) : VW'(part);
                end
            end
        end
    end

    assign vout    = v_reg[DIV_STEPS-1];
    assign quo_x   = quo_reg[DIV_STEPS-1][0];
    assign quo_y   = quo_reg[DIV_STEPS-1][1];
    assign tag_out = tag_reg[DIV_STEPS-1];

endmodule
`default_nettype wire

FILE: sv/quadratic_root_solver.sv
// Top level of the quadratic root solver
// The pipeline has 2 front, 32 square root, 1 numerator, 35 divider and
// 1 output stage.
// Throughput: one request per cycle; the whole pipeline holds while a result
// waits under out_stall.
// Reset: rst_n clears all valid bits asynchronously; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module quadratic_root_solver
    import qrs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic signed [CW-1:0] coef_quad,
    input  wire logic signed [CW-1:0] coef_lin,
    input  wire logic signed [CW-1:0] coef_const,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic signed [OW-1:0]      first_real,
    output logic signed [OW-1:0]      first_imag,
    output logic signed [OW-1:0]      second_real,
    output logic signed [OW-1:0]      second_imag,
    output logic [1:0]                status
);

    // Saturate an unsigned quotient magnitude with sign into Q16.16
    function automatic logic [OW:0] sat_q(input logic [QW-1:0] q, input logic neg);
        logic [OW:0] r;
        if (!neg)
        begin
            if (q > QW'(32'h7FFF_FFFF))
                r = {1'b1, 32'h7FFF_FFFF};
            else
                r = {1'b0, q[OW-1:0]};
        end
        else
        begin
            if (q > QW'(33'h1_0000_0000 >> 1))
                r = {1'b1, 32'h8000_0000};
            else
                r = {1'b0, OW'(-q[OW-1:0])};
        end
        return r;
    endfunction

    logic en;

    logic       f_v;
    logic [XW-1:0] f_rad;
    sqrt_tag_t  f_tag;

    logic       s_v;
    logic [RW-1:0] s_root;
    sqrt_tag_t  s_tag;

    logic signed [NW-1:0] nx, ny;
    logic [NW-1:0]        ux, uy;
    logic [VW-1:0]        ua;
    logic                 n_v_reg;
    logic [QW-1:0]        nx_reg, ny_reg;
    logic [VW-1:0]        den_reg;
    div_tag_t             n_tag_reg;
    div_tag_t             n_tag_next;

    logic       d_v;
    logic [QW-1:0] qx, qy;
    div_tag_t   d_tag;

    logic [OW:0] sx, sy, sy_neg;
    logic        o_v_reg;
    logic [OW-1:0] fr_reg, fi_reg, sr_reg, si_reg;
    logic [OW-1:0] fr_next, fi_next, sr_next, si_next;
    status_t     st_reg, st_next;

    // Global advance: hold everything while the result waits
    assign en       = !(o_v_reg && out_stall);
    assign in_stall = !en;

    qrs_front u_front (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .vin  (in_valid),
        .quad (coef_quad),
        .lin  (coef_lin),
        .cnst (coef_const),
        .vout (f_v),
        .rad  (f_rad),
        .tag  (f_tag)
    );

    qrs_isqrt u_isqrt (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .vin    (f_v),
        .rad    (f_rad),
        .tag_in (f_tag),
        .vout   (s_v),
        .root   (s_root),
        .tag_out(s_tag)
    );

    // Numerators: complex case -b and root, real case -b + root and -b - root
    always_comb
    begin
        nx = s_tag.cplx ? NW'(s_tag.neg_lin) : NW'(s_tag.neg_lin) + NW'(s_root);
        ny = s_tag.cplx ? NW'(s_root)        : NW'(s_tag.neg_lin) - NW'(s_root);
        ux = nx[NW-1] ? NW'(-nx) : NW'(nx);
        uy = ny[NW-1] ? NW'(-ny) : NW'(ny);
        ua = s_tag.quad[CW-1] ? VW'(-VW'(s_tag.quad)) : VW'(s_tag.quad);
        n_tag_next.neg_x = nx[NW-1] != s_tag.quad[CW-1];
        n_tag_next.neg_y = ny[NW-1] != s_tag.quad[CW-1];
        n_tag_next.cplx  = s_tag.cplx;
        n_tag_next.zero  = s_tag.zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_v_reg <= 1'b0;
        else if (en)
            n_v_reg <= s_v;
    end

    // Rounded division as (2n + a) / 2a
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg    <= (QW'(ux) << 1) + QW'(ua);
            ny_reg    <= (QW'(uy) << 1) + QW'(ua);
            den_reg   <= ua << 1;
            n_tag_reg <= n_tag_next;
        end
    end

    qrs_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .vin    (n_v_reg),
        .num_x  (nx_reg),
        .num_y  (ny_reg),
        .den    (den_reg),
        .tag_in (n_tag_reg),
        .vout   (d_v),
        .quo_x  (qx),
        .quo_y  (qy),
        .tag_out(d_tag)
    );

    // Output stage: sign, saturation and special cases
    always_comb
    begin
        sx     = sat_q(qx, d_tag.neg_x);
        sy     = sat_q(qy, d_tag.neg_y);
        sy_neg = sat_q(qy, !d_tag.neg_y);
        fr_next = sx[OW-1:0];
        if (d_tag.cplx)
        begin
            fi_next = sy[OW-1:0];
            sr_next = sx[OW-1:0];
            si_next = sy_neg[OW-1:0];
            st_next = (sx[OW] || sy[OW] || sy_neg[OW]) ? ST_SAT : ST_OK;
        end
        else
        begin
            fi_next = '0;
            sr_next = sy[OW-1:0];
            si_next = '0;
            st_next = (sx[OW] || sy[OW]) ? ST_SAT : ST_OK;
        end
        if (d_tag.zero)
        begin
            fr_next = '0;
            fi_next = '0;
            sr_next = '0;
            si_next = '0;
            st_next = ST_AZERO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_v_reg <= 1'b0;
        else if (en)
            o_v_reg <= d_v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fr_reg <= fr_next;
            fi_reg <= fi_next;
            sr_reg <= sr_next;
            si_reg <= si_next;
            st_reg <= st_next;
        end
    end

    assign out_valid   = o_v_reg;
    assign first_real  = fr_reg;
    assign first_imag  = fi_reg;
    assign second_real = sr_reg;
    assign second_imag = si_reg;
    assign status      = st_reg;

endmodule
`default_nettype wire

FILE: sv/qrs_checker.sv
// Port-level checker for the quadratic root solver, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module qrs_checker
    import qrs_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] first_real,
    input wire logic [31:0] first_imag,
    input wire logic [31:0] second_real,
    input wire logic [31:0] second_imag,
    input wire logic [1:0]  status
);

    // Status never carries an unused code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_AZERO || status == ST_SAT))
        else $error("status code out of range");

    // A zero quadratic coefficient yields all-zero roots
    a_zero_roots: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_AZERO) |->
        (first_real == '0 && first_imag == '0 && second_real == '0 && second_imag == '0))
        else $error("nonzero roots with zero quadratic coefficient");

    // Unsaturated roots have opposite imaginary parts
    a_conj: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_OK) |-> (first_imag == 32'(-second_imag)))
        else $error("imaginary parts are not opposite");

    // Complex roots share one real part
    a_same_real: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_OK && first_imag != '0) |-> (first_real == second_real))
        else $error("complex roots with different real parts");

    // Input is held off exactly while a result is stalled
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow output stall");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .first_real (first_real),
    .first_imag (first_imag),
    .second_real(second_real),
    .second_imag(second_imag),
    .status     (status)
);
`default_nettype wire
